/* hdl/gmd_pkg.sv */
package gmd_pkg;

	localparam int MAX_ROWS_DEF = 64;
	localparam int MAX_COLS_DEF = 64;
	localparam int CFG_W = 7;
	localparam int CFG_RESET = 64;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam int STEP_W = 12;
	localparam int LEN_W = 12;
	localparam int LEN_MAX = 4095;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_RUN,
		CMD_READ,
		CMD_NONE
	} cmd_t;

	typedef enum logic [1:0] {
		CELL_WALL,
		CELL_OPEN,
		CELL_START,
		CELL_TARGET
	} cell_t;

	typedef enum logic [1:0] {
		DIR_LEFT,
		DIR_RIGHT,
		DIR_UP,
		DIR_DOWN
	} dir_t;

	typedef enum logic {
		REG_ROW_COUNT,
		REG_COL_COUNT
	} reg_t;

endpackage

/* hdl/gmd_if.sv */
interface gmd_req_if;
	import gmd_pkg::*;

	logic             valid;
	logic             ready;
	cmd_t             cmd;
	cell_t            cell_code;
	logic [STEP_W-1:0] step_index;

	modport source(output valid, cmd, cell_code, step_index, input ready);
	modport sink(input valid, cmd, cell_code, step_index, output ready);
endinterface

interface gmd_rsp_if;
	import gmd_pkg::*;

	logic             valid;
	logic             ready;
	logic             found;
	logic [LEN_W-1:0] path_length;
	dir_t             direction;
	logic             step_ok;

	modport source(output valid, found, path_length, direction, step_ok, input ready);
	modport sink(input valid, found, path_length, direction, step_ok, output ready);
endinterface

/* hdl/grid_maze_dfs_path.sv */
// Load and unused commands go from S_EXEC to S_RESP; read adds S_RD1 for the path RAM.
// Run: two divider passes (start, then target), a clear of the visited marks of all
// MAX_ROWS*MAX_COLS cells, then the neighbour probes and the path steps (length
// pass, then store pass); a failed check goes from S_EXEC straight to S_RESP.
// One transaction in flight at a time; the result register frees the input side.
// arst_n clears the grid marks, lengths, found flag and handshake state.
module grid_maze_dfs_path #(
	parameter int MAX_ROWS = gmd_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = gmd_pkg::MAX_COLS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [gmd_pkg::APB_AW-1:0] paddr,
	input  logic [gmd_pkg::APB_DW-1:0] pwdata,
	output logic [gmd_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	gmd_req_if.sink                    req,
	gmd_rsp_if.source                  rsp
);
	import gmd_pkg::*;

	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int CW    = $clog2(CELLS);
	localparam int LW    = $clog2(CELLS + 1);
	localparam int RB    = $clog2(MAX_ROWS);
	localparam int CB    = $clog2(MAX_COLS);
	localparam int DRW   = $clog2(MAX_ROWS + 1);
	localparam int DCW   = $clog2(MAX_COLS + 1);
	localparam int SW    = CW + RB + CB + 3;
	localparam int MVW   = 1 + CW + RB + CB;
	localparam int SATW  = (LW > LEN_W) ? LW : LEN_W;

	typedef enum logic [4:0] {
		S_IDLE, S_EXEC, S_RD1, S_DIV_S, S_DIV_T, S_CLR, S_INIT, S_STEP, S_POP,
		S_CHK, S_T0, S_T1, S_L1, S_L2, S_P1, S_P2, S_RESP
	} state_t;

	state_t           state_q;
	cmd_t             cmd_q;
	cell_t            code_q;
	logic [STEP_W-1:0] idx_q;
	logic [CFG_W-1:0] row_cfg;
	logic [CFG_W-1:0] col_cfg;
	logic [DRW-1:0]   rows;
	logic [DCW-1:0]   cols;
	logic [CFG_W+DRW-1:0] row_x;
	logic [CFG_W+DCW-1:0] col_x;
	logic [DRW+DCW-1:0] prod;
	logic [LW-1:0]    total_q;

	logic [LW-1:0]    load_pos_q;
	logic [CW-1:0]    start_q;
	logic [CW-1:0]    target_q;
	logic [1:0]       marks_q;
	logic [1:0]       marks_base;
	logic             set_start;
	logic             set_target;
	logic             found_q;
	logic [LW-1:0]    slen_q;

	logic [RB-1:0]    sr_q;
	logic [CB-1:0]    sc_q;
	logic [RB-1:0]    tr_q;
	logic [CB-1:0]    tc_q;
	logic [CW-1:0]    clr_q;
	logic [LW-1:0]    sp_q;
	logic [LW-1:0]    sp_dec;
	logic [CW-1:0]    top_cell_q;
	logic [RB-1:0]    top_r_q;
	logic [CB-1:0]    top_c_q;
	logic [2:0]       top_d_q;
	logic [CW-1:0]    nb_cell_q;
	logic [RB-1:0]    nb_r_q;
	logic [CB-1:0]    nb_c_q;
	dir_t             nb_dir_q;
	logic [CW-1:0]    cur_cell_q;
	logic [RB-1:0]    cur_r_q;
	logic [CB-1:0]    cur_c_q;
	logic             fail_q;
	logic [LW-1:0]    len_q;
	logic [LW-1:0]    k_q;
	logic [LW-1:0]    k_dec;
	dir_t             dir_q;
	logic             ok_q;

	logic             rsp_valid_q;
	logic             rsp_found_q;
	logic [LEN_W-1:0] rsp_len_q;
	dir_t             rsp_dir_q;
	logic             rsp_ok_q;

	logic [MVW-1:0]   mv;
	logic [MVW-1:0]   wk;
	logic             run_ok;
	logic             read_ok;
	logic             enter;
	logic [SATW-1:0]  idx_x;
	logic [SATW-1:0]  slen_x;

	logic             div_start;
	logic             div_done;
	logic [CW-1:0]    div_num;
	logic [CW-1:0]    div_quo;
	logic [DCW-1:0]   div_rem;

	logic             map_we;
	logic [1:0]       map_rd;
	logic             mark_we;
	logic [CW-1:0]    mark_waddr;
	logic [2:0]       mark_wdata;
	logic [CW-1:0]    mark_raddr;
	logic [2:0]       mark_rd;
	logic             stk_we;
	logic [SW-1:0]    stk_rd;
	logic             path_we;
	logic [1:0]       path_rd;

	function automatic logic [MVW-1:0] nbr(input logic [CW-1:0] pos, input logic [RB-1:0] r,
			input logic [CB-1:0] c, input dir_t d, input logic [DRW-1:0] nrows,
			input logic [DCW-1:0] ncols);
		logic          skip;
		logic [CW-1:0] nc;
		logic [RB-1:0] nr;
		logic [CB-1:0] ncol;
		skip = 1'b0;
		nc   = pos;
		nr   = r;
		ncol = c;
		unique case (d)
			DIR_LEFT: begin
				skip = (c == '0);
				nc   = pos - 1'b1;
				ncol = c - 1'b1;
			end
			DIR_RIGHT: begin
				skip = ((DCW+1)'(c) + 1'b1) >= (DCW+1)'(ncols);
				nc   = pos + 1'b1;
				ncol = c + 1'b1;
			end
			DIR_UP: begin
				skip = (r == '0);
				nc   = pos - CW'(ncols);
				nr   = r - 1'b1;
			end
			DIR_DOWN: begin
				skip = ((DRW+1)'(r) + 1'b1) >= (DRW+1)'(nrows);
				nc   = pos + CW'(ncols);
				nr   = r + 1'b1;
			end
		endcase
		return {skip, nc, nr, ncol};
	endfunction

	gmd_apb u_apb (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.row_count(row_cfg),
		.col_count(col_cfg)
	);

	assign row_x = (CFG_W+DRW)'(row_cfg);
	assign col_x = (CFG_W+DCW)'(col_cfg);
	assign rows  = (row_cfg == '0) ? DRW'(1) :
		(row_x > (CFG_W+DRW)'(MAX_ROWS)) ? DRW'(MAX_ROWS) : row_x[DRW-1:0];
	assign cols  = (col_cfg == '0) ? DCW'(1) :
		(col_x > (CFG_W+DCW)'(MAX_COLS)) ? DCW'(MAX_COLS) : col_x[DCW-1:0];
	assign prod  = (DRW+DCW)'(rows) * (DRW+DCW)'(cols);

	assign marks_base = (load_pos_q == '0) ? 2'b00 : marks_q;
	assign set_start  = (code_q == CELL_START) && !marks_base[0];
	assign set_target = (code_q == CELL_TARGET) && !marks_base[1];

	assign run_ok  = (marks_q == 2'b11) && (LW'(start_q) < total_q) && (LW'(target_q) < total_q);
	assign idx_x   = SATW'(idx_q);
	assign slen_x  = SATW'(slen_q);
	assign read_ok = found_q && (idx_x < slen_x) && (idx_x < SATW'(CELLS));

	assign mv     = nbr(top_cell_q, top_r_q, top_c_q, dir_t'(top_d_q[1:0]), rows, cols);
	assign wk     = nbr(cur_cell_q, cur_r_q, cur_c_q, dir_t'(mark_rd[1:0] ^ 2'b01), rows, cols);
	assign enter  = !mark_rd[2] && (cell_t'(map_rd) == CELL_OPEN || cell_t'(map_rd) == CELL_TARGET);
	assign sp_dec = sp_q - 1'b1;
	assign k_dec  = k_q - 1'b1;

	assign div_start = (state_q == S_EXEC && cmd_q == CMD_RUN && run_ok) ||
		(state_q == S_DIV_S && div_done);
	assign div_num   = (state_q == S_EXEC) ? start_q : target_q;

	gmd_divmod #(.NW(CW), .DW(DCW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (cols),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	assign map_we = (state_q == S_EXEC) && (cmd_q == CMD_LOAD) && (load_pos_q < total_q);

	gmd_ram #(.WIDTH(2), .DEPTH(CELLS)) u_map (
		.clk  (clk),
		.we   (map_we),
		.waddr(load_pos_q[CW-1:0]),
		.wdata(code_q),
		.raddr(mv[CB+RB+CW-1:CB+RB]),
		.rdata(map_rd)
	);

	always_comb begin
		mark_we    = 1'b0;
		mark_waddr = nb_cell_q;
		mark_wdata = {1'b1, nb_dir_q};
		unique case (state_q)
			S_CLR: begin
				mark_we    = 1'b1;
				mark_waddr = clr_q;
				mark_wdata = 3'b000;
			end
			S_INIT: begin
				mark_we    = 1'b1;
				mark_waddr = start_q;
				mark_wdata = {1'b1, DIR_LEFT};
			end
			S_CHK: mark_we = enter;
			default: mark_we = 1'b0;
		endcase
	end

	always_comb begin
		unique case (state_q)
			S_T0:       mark_raddr = target_q;
			S_L1, S_P1: mark_raddr = cur_cell_q;
			default:    mark_raddr = mv[CB+RB+CW-1:CB+RB];
		endcase
	end

	gmd_ram #(.WIDTH(3), .DEPTH(CELLS)) u_mark (
		.clk  (clk),
		.we   (mark_we),
		.waddr(mark_waddr),
		.wdata(mark_wdata),
		.raddr(mark_raddr),
		.rdata(mark_rd)
	);

	assign stk_we = (state_q == S_CHK) && enter;

	gmd_ram #(.WIDTH(SW), .DEPTH(CELLS)) u_stack (
		.clk  (clk),
		.we   (stk_we),
		.waddr(sp_q[CW-1:0]),
		.wdata({top_cell_q, top_r_q, top_c_q, top_d_q}),
		.raddr(sp_dec[CW-1:0]),
		.rdata(stk_rd)
	);

	assign path_we = (state_q == S_P2);

	gmd_ram #(.WIDTH(2), .DEPTH(CELLS)) u_path (
		.clk  (clk),
		.we   (path_we),
		.waddr(k_dec[CW-1:0]),
		.wdata(mark_rd[1:0]),
		.raddr(idx_x[CW-1:0]),
		.rdata(path_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= CMD_NONE;
			code_q      <= CELL_WALL;
			idx_q       <= '0;
			total_q     <= '0;
			load_pos_q  <= '0;
			start_q     <= '0;
			target_q    <= '0;
			marks_q     <= '0;
			found_q     <= 1'b0;
			slen_q      <= '0;
			sr_q        <= '0;
			sc_q        <= '0;
			tr_q        <= '0;
			tc_q        <= '0;
			clr_q       <= '0;
			sp_q        <= '0;
			top_cell_q  <= '0;
			top_r_q     <= '0;
			top_c_q     <= '0;
			top_d_q     <= '0;
			nb_cell_q   <= '0;
			nb_r_q      <= '0;
			nb_c_q      <= '0;
			nb_dir_q    <= DIR_LEFT;
			cur_cell_q  <= '0;
			cur_r_q     <= '0;
			cur_c_q     <= '0;
			fail_q      <= 1'b0;
			len_q       <= '0;
			k_q         <= '0;
			dir_q       <= DIR_LEFT;
			ok_q        <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_found_q <= 1'b0;
			rsp_len_q   <= '0;
			rsp_dir_q   <= DIR_LEFT;
			rsp_ok_q    <= 1'b0;
		end else begin
			total_q <= LW'(prod);
			if (rsp_valid_q && rsp.ready && state_q != S_RESP) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q   <= req.cmd;
						code_q  <= req.cell_code;
						idx_q   <= req.step_index;
						dir_q   <= DIR_LEFT;
						ok_q    <= 1'b0;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (cmd_q)
						CMD_LOAD: begin
							if (load_pos_q < total_q) begin
								marks_q    <= marks_base | {set_target, set_start};
								if (set_start) begin
									start_q <= load_pos_q[CW-1:0];
								end
								if (set_target) begin
									target_q <= load_pos_q[CW-1:0];
								end
								load_pos_q <= load_pos_q + 1'b1;
							end
							state_q <= S_RESP;
						end
						CMD_RUN: begin
							found_q    <= 1'b0;
							slen_q     <= '0;
							sp_q       <= '0;
							load_pos_q <= '0;
							state_q    <= run_ok ? S_DIV_S : S_RESP;
						end
						CMD_READ: begin
							ok_q    <= read_ok;
							state_q <= S_RD1;
						end
						default: state_q <= S_RESP;
					endcase
				end
				S_RD1: begin
					if (ok_q) begin
						dir_q <= dir_t'(path_rd);
					end
					state_q <= S_RESP;
				end
				S_DIV_S: begin
					if (div_done) begin
						sr_q    <= div_quo[RB-1:0];
						sc_q    <= div_rem[CB-1:0];
						state_q <= S_DIV_T;
					end
				end
				S_DIV_T: begin
					if (div_done) begin
						tr_q    <= div_quo[RB-1:0];
						tc_q    <= div_rem[CB-1:0];
						clr_q   <= '0;
						state_q <= S_CLR;
					end
				end
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CW'(CELLS - 1)) begin
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					top_cell_q <= start_q;
					top_r_q    <= sr_q;
					top_c_q    <= sc_q;
					top_d_q    <= '0;
					state_q    <= S_STEP;
				end
				S_STEP: begin
					if (top_d_q[2]) begin
						if (sp_q == '0) begin
							state_q <= S_T0;
						end else begin
							sp_q    <= sp_dec;
							state_q <= S_POP;
						end
					end else begin
						top_d_q <= top_d_q + 1'b1;
						if (!mv[MVW-1]) begin
							{nb_cell_q, nb_r_q, nb_c_q} <= mv[MVW-2:0];
							nb_dir_q <= dir_t'(top_d_q[1:0]);
							state_q  <= S_CHK;
						end
					end
				end
				S_POP: begin
					{top_cell_q, top_r_q, top_c_q, top_d_q} <= stk_rd;
					state_q <= S_STEP;
				end
				S_CHK: begin
					if (enter) begin
						sp_q       <= sp_q + 1'b1;
						top_cell_q <= nb_cell_q;
						top_r_q    <= nb_r_q;
						top_c_q    <= nb_c_q;
						top_d_q    <= '0;
					end
					state_q <= S_STEP;
				end
				S_T0: state_q <= S_T1;
				S_T1: begin
					if (!mark_rd[2]) begin
						state_q <= S_RESP;
					end else begin
						cur_cell_q <= target_q;
						cur_r_q    <= tr_q;
						cur_c_q    <= tc_q;
						len_q      <= '0;
						fail_q     <= 1'b0;
						state_q    <= S_L1;
					end
				end
				S_L1: begin
					if (cur_cell_q == start_q || fail_q || len_q >= total_q) begin
						k_q        <= len_q;
						cur_cell_q <= target_q;
						cur_r_q    <= tr_q;
						cur_c_q    <= tc_q;
						fail_q     <= 1'b0;
						state_q    <= S_P1;
					end else begin
						state_q <= S_L2;
					end
				end
				S_L2: begin
					len_q <= len_q + 1'b1;
					if (wk[MVW-1]) begin
						fail_q <= 1'b1;
					end else begin
						{cur_cell_q, cur_r_q, cur_c_q} <= wk[MVW-2:0];
					end
					state_q <= S_L1;
				end
				S_P1: begin
					if (k_q == '0 || fail_q) begin
						found_q <= 1'b1;
						slen_q  <= len_q;
						state_q <= S_RESP;
					end else begin
						state_q <= S_P2;
					end
				end
				S_P2: begin
					k_q <= k_dec;
					if (wk[MVW-1]) begin
						fail_q <= 1'b1;
					end else begin
						{cur_cell_q, cur_r_q, cur_c_q} <= wk[MVW-2:0];
					end
					state_q <= S_P1;
				end
				S_RESP: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_found_q <= found_q;
						rsp_len_q   <= (slen_x > SATW'(LEN_MAX)) ? LEN_W'(LEN_MAX) :
							slen_x[LEN_W-1:0];
						rsp_dir_q   <= dir_q;
						rsp_ok_q    <= ok_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.found       = rsp_found_q;
	assign rsp.path_length = rsp_len_q;
	assign rsp.direction   = rsp_dir_q;
	assign rsp.step_ok     = rsp_ok_q;

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= LW'(CELLS))
		else $error("search stack overflow");

	a_ok_needs_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (!rsp_ok_q || rsp_found_q))
		else $error("step reported without a found path");

	a_dir_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_ok_q) |-> (rsp_dir_q == DIR_LEFT))
		else $error("direction given for a failed read");

	a_chk_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK) |-> ($past(state_q) == S_STEP))
		else $error("neighbour check without a probe");
endmodule

/* hdl/gmd_ram.sv */
module gmd_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* hdl/gmd_divmod.sv */
module gmd_divmod #(
	parameter int NW = 12,
	parameter int DW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient,
	output logic [DW-1:0] remainder
);
	localparam int CNTW = $clog2(NW + 1);

	logic [NW-1:0]   num_q;
	logic [DW-1:0]   rem_q;
	logic [CNTW-1:0] cnt_q;
	logic            done_q;
	logic [DW:0]     rem_sh;
	logic [DW:0]     rem_diff;
	logic            ge;

	assign rem_sh   = {rem_q, num_q[NW-1]};
	assign ge       = rem_sh >= {1'b0, divisor};
	assign rem_diff = rem_sh - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				num_q <= dividend;
				rem_q <= '0;
				cnt_q <= CNTW'(NW);
			end else if (cnt_q != '0) begin
				num_q <= {num_q[NW-2:0], ge};
				rem_q <= ge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign quotient  = num_q;
	assign remainder = rem_q;
endmodule

/* hdl/gmd_apb.sv */
module gmd_apb (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gmd_pkg::APB_AW-1:0]  paddr,
	input  logic [gmd_pkg::APB_DW-1:0]  pwdata,
	output logic [gmd_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output logic [gmd_pkg::CFG_W-1:0]   row_count,
	output logic [gmd_pkg::CFG_W-1:0]   col_count
);
	import gmd_pkg::*;

	logic [CFG_W-1:0] row_q;
	logic [CFG_W-1:0] col_q;
	reg_t             sel;

	assign sel    = reg_t'(paddr[2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= CFG_W'(CFG_RESET);
			col_q <= CFG_W'(CFG_RESET);
		end else if (psel && penable && pwrite) begin
			unique case (sel)
				REG_ROW_COUNT: row_q <= pwdata[CFG_W-1:0];
				REG_COL_COUNT: col_q <= pwdata[CFG_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_ROW_COUNT: prdata = APB_DW'(row_q);
			REG_COL_COUNT: prdata = APB_DW'(col_q);
		endcase
	end

	assign row_count = row_q;
	assign col_count = col_q;
endmodule

/* dv/tb_grid_maze_dfs_path.sv */
`timescale 1ns / 100ps

module tb_grid_maze_dfs_path;
	import gmd_pkg::*;

	localparam int CELLS = MAX_ROWS_DEF * MAX_COLS_DEF;
	localparam int LIMIT = 3000000;
	localparam int ITEMS = 1650;

	typedef struct {
		bit   found;
		logic [LEN_W-1:0] len;
		dir_t dir;
		bit   ok;
	} maze_rsp_t;

	typedef struct {
		bit    cfg;
		reg_t  ra;
		int    val;
		cmd_t  cmd;
		cell_t code;
		int    idx;
		bit    typed;
		bit    found;
		int    len;
		dir_t  dir;
		bit    ok;
	} stim_row_t;

	localparam int NROWS = 20;
	stim_row_t stim_rows [NROWS] = '{
		'{0, REG_ROW_COUNT, 0, CMD_READ, CELL_WALL, 0, 1, 0, 0, DIR_LEFT, 0},
		'{0, REG_ROW_COUNT, 0, CMD_NONE, CELL_TARGET, 4095, 1, 0, 0, DIR_LEFT, 0},
		'{0, REG_ROW_COUNT, 0, CMD_RUN, CELL_WALL, 0, 1, 0, 0, DIR_LEFT, 0},
		'{1, REG_ROW_COUNT, 2, CMD_LOAD, CELL_WALL, 0, 0, 0, 0, DIR_LEFT, 0},
		'{1, REG_COL_COUNT, 3, CMD_LOAD, CELL_WALL, 0, 0, 0, 0, DIR_LEFT, 0},
		'{0, REG_ROW_COUNT, 0, CMD_LOAD, CELL_START, 0, 0, 0, 0, DIR_LEFT, 0},
		'{0, REG_ROW_COUNT, 0, CMD_LOAD, CELL_OPEN, 0, 0, 0, 0, DIR_LEFT, 0},
		'{0, REG_ROW_COUNT, 0, CMD_LOAD, CELL_WALL, 0, 0, 0, 0, DIR_LEFT, 0},
		'{0, REG_ROW_COUNT, 0, CMD_LOAD, CELL_START, 0, 0, 0, 0, DIR_LEFT, 0},
		'{0, REG_ROW_COUNT, 0, CMD_LOAD, CELL_TARGET, 0, 0, 0, 0, DIR_LEFT, 0},
		'{0, REG_ROW_COUNT, 0, CMD_LOAD, CELL_TARGET, 0, 0, 0, 0, DIR_LEFT, 0},
		'{0, REG_ROW_COUNT, 0, CMD_LOAD, CELL_OPEN, 0, 0, 0, 0, DIR_LEFT, 0},
		'{0, REG_ROW_COUNT, 0, CMD_RUN, CELL_WALL, 0, 0, 0, 0, DIR_LEFT, 0},
		'{0, REG_ROW_COUNT, 0, CMD_READ, CELL_WALL, 0, 0, 0, 0, DIR_LEFT, 0},
		'{0, REG_ROW_COUNT, 0, CMD_READ, CELL_WALL, 1, 0, 0, 0, DIR_LEFT, 0},
		'{0, REG_ROW_COUNT, 0, CMD_READ, CELL_WALL, 2, 0, 0, 0, DIR_LEFT, 0},
		'{0, REG_ROW_COUNT, 0, CMD_READ, CELL_WALL, 4095, 0, 0, 0, DIR_LEFT, 0},
		'{1, REG_COL_COUNT, 1, CMD_LOAD, CELL_WALL, 0, 0, 0, 0, DIR_LEFT, 0},
		'{0, REG_ROW_COUNT, 0, CMD_RUN, CELL_WALL, 0, 1, 0, 0, DIR_LEFT, 0},
		'{0, REG_ROW_COUNT, 0, CMD_READ, CELL_WALL, 0, 1, 0, 0, DIR_LEFT, 0}
	};

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	gmd_req_if req_if();
	gmd_rsp_if rsp_if();

	grid_maze_dfs_path u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req(req_if),
		.rsp(rsp_if)
	);

	cell_t     gm_map [CELLS];
	bit        gm_seen [CELLS];
	bit        gm_vis [CELLS];
	dir_t      gm_edir [CELLS];
	int        gm_stack [CELLS];
	dir_t      gm_path [CELLS];
	int        gm_rows;
	int        gm_cols;
	int        gm_len;
	bit        gm_found;
	int        gm_loadpos;
	int        gm_start;
	int        gm_target;
	bit [1:0]  gm_marks;

	maze_rsp_t pending_rsp [$];
	int        errors;
	int        cycles;
	int        n_items;
	int        burst_left;
	bit        hold_off;
	bit        hold_done;
	int        calm;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic int clamp_dim(int v);
		if (v == 0) return 1;
		if (v > 64) return 64;
		return v;
	endfunction

	function automatic int entered_from(int pos, dir_t d, int cols, int total);
		int r;
		int c;
		r = pos / cols;
		c = pos % cols;
		case (d)
			DIR_LEFT: return (c + 1 >= cols) ? total : pos + 1;
			DIR_RIGHT: return (c == 0) ? total : pos - 1;
			DIR_UP: return (r + 1 >= total / cols) ? total : pos + cols;
			default: return (r == 0) ? total : pos - cols;
		endcase
	endfunction

	function automatic void search_maze();
		int rows;
		int cols;
		int total;
		int pos;
		int len;
		int k;
		int top;
		int d;
		int r;
		int c;
		int nb;
		int sp;
		rows = clamp_dim(gm_rows);
		cols = clamp_dim(gm_cols);
		total = rows * cols;
		for (int i = 0; i < CELLS; i++) gm_vis[i] = 0;
		gm_found = 0;
		gm_len = 0;
		gm_loadpos = 0;
		if (gm_marks != 2'b11 || gm_start >= total || gm_target >= total) return;
		gm_vis[gm_start] = 1;
		gm_stack[0] = gm_start << 3;
		sp = 1;
		while (sp > 0) begin
			top = gm_stack[sp-1];
			d = top & 7;
			pos = top >> 3;
			if (d >= 4) begin
				sp--;
				continue;
			end
			gm_stack[sp-1] = (pos << 3) | (d + 1);
			r = pos / cols;
			c = pos % cols;
			nb = -1;
			case (d)
				0: if (c != 0) nb = pos - 1;
				1: if (c + 1 < cols) nb = pos + 1;
				2: if (r != 0) nb = pos - cols;
				default: if (r + 1 < rows) nb = pos + cols;
			endcase
			if (nb < 0) continue;
			if (gm_vis[nb] || !(gm_map[nb] == CELL_OPEN || gm_map[nb] == CELL_TARGET)) continue;
			gm_vis[nb] = 1;
			gm_edir[nb] = dir_t'(d);
			if (sp < CELLS) begin
				gm_stack[sp] = nb << 3;
				sp++;
			end
		end
		if (!gm_vis[gm_target]) return;
		pos = gm_target;
		len = 0;
		while (pos != gm_start && pos < total && len < total) begin
			pos = entered_from(pos, gm_edir[pos], cols, total);
			len++;
		end
		pos = gm_target;
		k = len;
		while (k > 0 && pos < total) begin
			k--;
			gm_path[k] = gm_edir[pos];
			pos = entered_from(pos, gm_edir[pos], cols, total);
		end
		gm_found = 1;
		gm_len = len;
	endfunction

	function automatic maze_rsp_t predict_maze(cmd_t cmd, cell_t code, int idx);
		maze_rsp_t e;
		int p;
		e.dir = DIR_LEFT;
		e.ok = 0;
		case (cmd)
			CMD_LOAD: begin
				if (gm_loadpos < clamp_dim(gm_rows) * clamp_dim(gm_cols)) begin
					p = gm_loadpos;
					if (p == 0) gm_marks = 0;
					gm_map[p] = code;
					gm_seen[p] = 1;
					if (code == CELL_START && !gm_marks[0]) begin
						gm_start = p;
						gm_marks[0] = 1;
					end
					if (code == CELL_TARGET && !gm_marks[1]) begin
						gm_target = p;
						gm_marks[1] = 1;
					end
					gm_loadpos = p + 1;
				end
			end
			CMD_RUN: search_maze();
			CMD_READ: begin
				if (gm_found && idx < gm_len) begin
					e.dir = gm_path[idx];
					e.ok = 1;
				end
			end
			default: ;
		endcase
		e.found = gm_found;
		e.len = (gm_len > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(gm_len);
		return e;
	endfunction

	function automatic bit grid_written();
		int total;
		total = clamp_dim(gm_rows) * clamp_dim(gm_cols);
		for (int i = 0; i < total; i++)
			if (!gm_seen[i]) return 0;
		return 1;
	endfunction

	task automatic send_item(cmd_t cmd, cell_t code, int idx, bit typed, maze_rsp_t typed_rsp);
		maze_rsp_t e;
		if (burst_left == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
		end
		burst_left--;
		req_if.valid <= 1'b1;
		req_if.cmd <= cmd;
		req_if.cell_code <= code;
		req_if.step_index <= idx[STEP_W-1:0];
		do @(posedge clk); while (!req_if.ready);
		e = predict_maze(cmd, code, idx);
		pending_rsp.push_back(typed ? typed_rsp : e);
		n_items++;
	endtask

	task automatic send_plain(cmd_t cmd, cell_t code, int idx);
		maze_rsp_t none;
		none = '{0, '0, DIR_LEFT, 0};
		send_item(cmd, code, idx, 0, none);
	endtask

	task automatic wait_idle();
		req_if.valid <= 1'b0;
		burst_left = 0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(reg_t ra, int val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'(4 * int'(ra));
		pwdata <= APB_DW'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (ra == REG_ROW_COUNT) gm_rows = val & 8'h7f;
		else gm_cols = val & 8'h7f;
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb_grid_maze_dfs_path: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		maze_rsp_t e;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected transaction found=%0d len=%0d", $time,
					rsp_if.found, rsp_if.path_length);
				errors++;
			end else begin
				e = pending_rsp.pop_front();
				if (rsp_if.found !== e.found || rsp_if.path_length !== e.len ||
					rsp_if.direction !== e.dir || rsp_if.step_ok !== e.ok) begin
					$display("%0t: expected found=%0d len=%0d dir=%0d ok=%0d, got %0d %0d %0d %0d",
						$time, e.found, e.len, e.dir, e.ok, rsp_if.found,
						rsp_if.path_length, rsp_if.direction, rsp_if.step_ok);
					errors++;
				end
			end
		end
	end

	initial begin
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off && !hold_done) begin
				rsp_if.ready <= 1'b0;
				repeat (600) @(posedge clk);
				hold_done = 1;
			end else if (calm > 0) begin
				rsp_if.ready <= 1'b1;
				calm--;
			end else begin
				rsp_if.ready <= ($urandom_range(0, 3) != 0);
				if ($urandom_range(0, 40) == 0) calm = $urandom_range(20, 80);
			end
		end
	end

	initial begin
		maze_rsp_t typed_rsp;
		int rows;
		int cols;
		int total;
		int s;
		int t;
		int variant;
		int lim;
		cell_t code;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_if.valid = 1'b0;
		req_if.cmd = CMD_LOAD;
		req_if.cell_code = CELL_WALL;
		req_if.step_index = '0;
		errors = 0;
		cycles = 0;
		n_items = 0;
		burst_left = 0;
		hold_off = 0;
		hold_done = 0;
		calm = 0;
		gm_rows = CFG_RESET;
		gm_cols = CFG_RESET;
		gm_len = 0;
		gm_found = 0;
		gm_loadpos = 0;
		gm_start = 0;
		gm_target = 0;
		gm_marks = 0;
		for (int i = 0; i < CELLS; i++) begin
			gm_map[i] = CELL_WALL;
			gm_seen[i] = 0;
			gm_vis[i] = 0;
			gm_edir[i] = DIR_LEFT;
			gm_path[i] = DIR_LEFT;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NROWS; i++) begin
			if (stim_rows[i].cfg) begin
				wait_idle();
				write_reg(stim_rows[i].ra, stim_rows[i].val);
			end else begin
				typed_rsp = '{stim_rows[i].found, LEN_W'(stim_rows[i].len),
					stim_rows[i].dir, stim_rows[i].ok};
				send_item(stim_rows[i].cmd, stim_rows[i].code, stim_rows[i].idx,
					stim_rows[i].typed, typed_rsp);
			end
		end

		while (n_items < ITEMS) begin
			wait_idle();
			variant = $urandom_range(0, 11);
			case (variant)
				0: begin rows = 0; cols = $urandom_range(1, 64); end
				1: begin rows = 127; cols = $urandom_range(0, 2); end
				2: begin rows = $urandom_range(1, 3); cols = $urandom_range(65, 127); end
				default: begin rows = $urandom_range(1, 8); cols = $urandom_range(1, 8); end
			endcase
			if ($urandom_range(0, 1)) begin
				write_reg(REG_ROW_COUNT, rows);
				write_reg(REG_COL_COUNT, cols);
			end else begin
				write_reg(REG_COL_COUNT, cols);
				write_reg(REG_ROW_COUNT, rows);
			end
			if (n_items > 300) hold_off = 1;
			total = clamp_dim(gm_rows) * clamp_dim(gm_cols);
			s = $urandom_range(0, total - 1);
			t = $urandom_range(0, total - 1);
			variant = $urandom_range(0, 9);
			for (int p = 0; p < total; p++) begin
				if ($urandom_range(0, 29) == 0)
					send_plain($urandom_range(0, 1) ? CMD_READ : CMD_NONE, cell_t'($urandom_range(0, 3)),
						$urandom_range(0, 4095));
				if ($urandom_range(0, 59) == 0 && grid_written())
					send_plain(CMD_RUN, cell_t'($urandom_range(0, 3)), $urandom_range(0, 4095));
				code = ($urandom_range(0, 3) == 0) ? CELL_WALL : CELL_OPEN;
				if (variant == 2 && $urandom_range(0, 5) == 0)
					code = $urandom_range(0, 1) ? CELL_START : CELL_TARGET;
				if (p == t && variant != 0) code = CELL_TARGET;
				if (p == s && variant != 1) code = CELL_START;
				send_plain(CMD_LOAD, code, $urandom_range(0, 4095));
			end
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 3)) send_plain(CMD_LOAD, cell_t'($urandom_range(0, 3)), 0);
			send_plain(CMD_RUN, cell_t'($urandom_range(0, 3)), $urandom_range(0, 4095));
			lim = (gm_len + 2 < 40) ? gm_len + 2 : 40;
			for (int k = 0; k < lim; k++)
				send_plain(CMD_READ, cell_t'($urandom_range(0, 3)), k);
			repeat (3) send_plain(CMD_READ, cell_t'($urandom_range(0, 3)), $urandom_range(0, 4095));
			if ($urandom_range(0, 3) == 0) begin
				send_plain(CMD_RUN, CELL_WALL, 0);
				send_plain(CMD_READ, CELL_WALL, $urandom_range(0, 3));
			end
		end

		req_if.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("tb_grid_maze_dfs_path: done, clean");
		end else begin
			$display("tb_grid_maze_dfs_path: done, errors");
		end
		$finish;
	end

endmodule
